FILE: rtl/pfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_pkg: shared definitions for the pipe byte FIFO
// Request and status codes, controller state type and the command bundle
// that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package pfe_pkg;

	localparam int CAPACITY_DEF = 4096;
	localparam int MAX_ENDS_DEF = 255;

	localparam int REQ_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 3;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CREATE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ADD    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DROP   = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BLOCK  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EOF    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BROKEN = 3'd3;
	localparam logic [STATUS_W-1:0] ST_UNUSED = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_LOAD = 3'b100
	} pfe_state_t;

	typedef struct packed {
		logic latch_req;
		logic exec;
		logic load_out;
	} pfe_cmd_t;

endpackage

FILE: rtl/pfe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_ctrl: request sequencer
// Takes one request at a time, steps the datapath through execute and
// result load, and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module pfe_ctrl
	import pfe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output pfe_cmd_t cmd
);

	pfe_state_t state_q;
	pfe_state_t state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d      = state_q;
		cmd.latch_req = 1'b0;
		cmd.exec      = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch_req = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = S_LOAD;
			end
			S_LOAD: begin
				// The result waits here until the output register has room.
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: rtl/pfe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_datapath: ring buffer, end counts and result register
// Holds the pipe state and byte store, decides each request in the execute
// step and assembles the result with the registered memory read data.
// ----------------------------------------------------------------------------
module pfe_datapath
	import pfe_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int MAX_ENDS = MAX_ENDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pfe_cmd_t            cmd,
	input  logic [REQ_W-1:0]    req_type,
	input  logic                end_sel,
	input  logic [BYTE_W-1:0]   write_byte,
	input  logic                final_byte,
	output logic [STATUS_W-1:0] status,
	output logic [BYTE_W-1:0]   read_byte,
	output logic                can_read,
	output logic                can_write,
	output logic                final_mark,
	output logic                pipe_live
);

	localparam int AW = $clog2(CAPACITY);
	localparam int FW = $clog2(CAPACITY + 1);
	localparam int CW = $clog2(MAX_ENDS + 1);

	// Latched request.
	logic [REQ_W-1:0]  req_q;
	logic              wend_q;
	logic [BYTE_W-1:0] wbyte_q;
	logic              fin_q;

	// Pipe state.
	logic          live_q;
	logic [CW-1:0] rcnt_q;
	logic [CW-1:0] wcnt_q;
	logic [FW-1:0] fill_q;
	logic [AW-1:0] wpos_q;
	logic [AW-1:0] rpos_q;

	logic          n_live;
	logic [CW-1:0] n_rcnt;
	logic [CW-1:0] n_wcnt;
	logic [FW-1:0] n_fill;
	logic [AW-1:0] n_wpos;
	logic [AW-1:0] n_rpos;
	logic [STATUS_W-1:0] n_status;
	logic          rd_ok;
	logic          wr_ok;

	// Result held between execute and load.
	logic [STATUS_W-1:0] res_status_q;
	logic                res_rd_ok_q;
	logic                res_can_read_q;
	logic                res_can_write_q;
	logic                res_live_q;
	logic                res_fin_q;

	logic [BYTE_W-1:0] mem [CAPACITY];
	logic [BYTE_W-1:0] mem_rdata_q;

	// Output register.
	logic [STATUS_W-1:0] status_q;
	logic [BYTE_W-1:0]   read_byte_q;
	logic                can_read_q;
	logic                can_write_q;
	logic                final_mark_q;
	logic                pipe_live_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_req) begin
			req_q   <= req_type;
			wend_q  <= end_sel;
			wbyte_q <= write_byte;
			fin_q   <= final_byte;
		end
	end

	always_comb begin
		n_live   = live_q;
		n_rcnt   = rcnt_q;
		n_wcnt   = wcnt_q;
		n_fill   = fill_q;
		n_wpos   = wpos_q;
		n_rpos   = rpos_q;
		n_status = ST_OK;
		rd_ok    = 1'b0;
		wr_ok    = 1'b0;
		if (req_q == REQ_CREATE) begin
			n_live = 1'b1;
			n_rcnt = CW'(1);
			n_wcnt = CW'(1);
			n_fill = '0;
			n_wpos = '0;
			n_rpos = '0;
		end else if (!live_q) begin
			n_status = ST_UNUSED;
		end else begin
			unique case (req_q)
				REQ_READ: begin
					if (fill_q != '0) begin
						rd_ok  = 1'b1;
						n_rpos = (rpos_q == AW'(CAPACITY - 1)) ? '0 : rpos_q + 1'b1;
						n_fill = fill_q - 1'b1;
					end else if (wcnt_q != '0) begin
						n_status = ST_BLOCK;
					end else begin
						n_status = ST_EOF;
					end
				end
				REQ_WRITE: begin
					if (rcnt_q == '0) begin
						n_status = ST_BROKEN;
					end else if (fill_q == FW'(CAPACITY)) begin
						n_status = ST_BLOCK;
					end else begin
						wr_ok  = 1'b1;
						n_wpos = (wpos_q == AW'(CAPACITY - 1)) ? '0 : wpos_q + 1'b1;
						n_fill = fill_q + 1'b1;
					end
				end
				REQ_ADD: begin
					// Counts saturate at the end limit.
					if (wend_q) begin
						if (wcnt_q != CW'(MAX_ENDS)) n_wcnt = wcnt_q + 1'b1;
					end else begin
						if (rcnt_q != CW'(MAX_ENDS)) n_rcnt = rcnt_q + 1'b1;
					end
				end
				REQ_DROP: begin
					if (wend_q) begin
						if (wcnt_q != '0) n_wcnt = wcnt_q - 1'b1;
					end else begin
						if (rcnt_q != '0) n_rcnt = rcnt_q - 1'b1;
					end
					// With no ends left the pipe is released and emptied.
					if (n_rcnt == '0 && n_wcnt == '0) begin
						n_live = 1'b0;
						n_fill = '0;
						n_wpos = '0;
						n_rpos = '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
			rcnt_q <= '0;
			wcnt_q <= '0;
			fill_q <= '0;
			wpos_q <= '0;
			rpos_q <= '0;
		end else if (cmd.exec) begin
			live_q <= n_live;
			rcnt_q <= n_rcnt;
			wcnt_q <= n_wcnt;
			fill_q <= n_fill;
			wpos_q <= n_wpos;
			rpos_q <= n_rpos;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q    <= n_status;
			res_rd_ok_q     <= rd_ok;
			res_can_read_q  <= !n_live || (n_fill != '0) || (n_wcnt == '0);
			res_can_write_q <= !n_live || (n_fill != FW'(CAPACITY)) || (n_rcnt == '0);
			res_live_q      <= n_live;
			res_fin_q       <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && wr_ok) begin
			mem[wpos_q] <= wbyte_q;
		end
		if (cmd.exec) begin
			mem_rdata_q <= mem[rpos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q     <= res_status_q;
			read_byte_q  <= res_rd_ok_q ? mem_rdata_q : '0;
			can_read_q   <= res_can_read_q;
			can_write_q  <= res_can_write_q;
			final_mark_q <= res_fin_q;
			pipe_live_q  <= res_live_q;
		end
	end

	assign status     = status_q;
	assign read_byte  = read_byte_q;
	assign can_read   = can_read_q;
	assign can_write  = can_write_q;
	assign final_mark = final_mark_q;
	assign pipe_live  = pipe_live_q;

endmodule

FILE: rtl/pipe_byte_fifo_with_end_counts_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipe_byte_fifo_with_end_counts_top: one pipe as a byte ring buffer
// Requests create the pipe, add or drop reader and writer ends, and read or
// write one byte. Each request returns exactly one result.
// ----------------------------------------------------------------------------
// Usage:
// A request is taken on the input channel when in_valid and in_ready are
// both high. It carries the request type, the end selector, the byte to
// write and a final-byte mark that is echoed in the result.
// The result appears on the output channel with out_valid after the request
// is taken: the execute step decides the request, updates the pointers and
// counts and reads the byte store into its register, then the load step
// moves the result into the output register once that register has room.
// One request is in flight at a time, so a new request is taken only after
// the accept, execute and load steps of the controller have run for the
// last one.
// The output register lets the next request be taken while a result waits.
// When the receiver stalls, the following result is held inside until the
// output register frees, and no further request is taken meanwhile.
// After reset there is no pipe; the byte store needs no clearing because a
// read only returns bytes that were written.
// ----------------------------------------------------------------------------
module pipe_byte_fifo_with_end_counts_top
	import pfe_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int MAX_ENDS = MAX_ENDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [REQ_W-1:0]    req_type,
	input  logic                end_sel,
	input  logic [BYTE_W-1:0]   write_byte,
	input  logic                final_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [BYTE_W-1:0]   read_byte,
	output logic                can_read,
	output logic                can_write,
	output logic                final_mark,
	output logic                pipe_live
);

	pfe_cmd_t cmd;

	pfe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	pfe_datapath #(
		.CAPACITY (CAPACITY),
		.MAX_ENDS (MAX_ENDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (req_type),
		.end_sel    (end_sel),
		.write_byte (write_byte),
		.final_byte (final_byte),
		.status     (status),
		.read_byte  (read_byte),
		.can_read   (can_read),
		.can_write  (can_write),
		.final_mark (final_mark),
		.pipe_live  (pipe_live)
	);

endmodule

FILE: rtl/pfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfe_checker: port-level checks for the pipe byte FIFO
// Watches the top level's ports and flags results that break the pipe rules.
// ----------------------------------------------------------------------------
module pfe_checker
	import pfe_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic [STATUS_W-1:0] status,
	input logic [BYTE_W-1:0]   read_byte,
	input logic                can_read,
	input logic                can_write,
	input logic                pipe_live
);

	// A stalled result keeps its status and byte.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_byte))
		else $error("stalled result changed");

	// Only a successful read returns a nonzero byte.
	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> read_byte == '0)
		else $error("byte returned on a failed request");

	// Without a live pipe both poll flags are set.
	a_poll: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pipe_live |-> can_read && can_write)
		else $error("poll flags clear without a pipe");

	// A request on a missing pipe leaves it missing.
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNUSED |-> !pipe_live)
		else $error("pipe reported live on an unused status");

	// End of file means no writers remain, so the read side polls ready.
	a_eof: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EOF |-> can_read && pipe_live)
		else $error("end of file without read readiness");

endmodule

bind pipe_byte_fifo_with_end_counts_top pfe_checker u_pfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.read_byte (read_byte),
	.can_read  (can_read),
	.can_write (can_write),
	.pipe_live (pipe_live)
);
